>>> src/sdq_pkg.sv
// sorted deadline queue: shared widths, command and status codes
// no dependencies; imported by sdq_remaining, sorted_deadline_queue_top and the bench
`default_nettype none

package sdq_pkg;

	localparam int ID_W     = 6;
	localparam int ID_SPACE = 64;
	localparam int DL_W     = 64;
	localparam int TL_W     = 32;
	localparam int CNT_W    = 7;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_W  = 136;
	localparam int OUT_W = 48;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EARLIEST = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
	localparam logic [STAT_W-1:0] STAT_DUP     = 2'd3;

endpackage

`default_nettype wire

>>> src/sdq_remaining.sv
// sorted deadline queue: registered time-left unit (compare and subtract)
// depends on sdq_pkg
`default_nettype none

module sdq_remaining (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sdq_pkg::DL_W-1:0]  due,
	input  logic [sdq_pkg::DL_W-1:0]  now,
	output logic [sdq_pkg::TL_W-1:0]  time_left_s1
);
	import sdq_pkg::*;

	logic [DL_W-1:0] diff;

	assign diff = due - now;

	// zero once the deadline is not later than now
	always_ff @(posedge clk) begin
		if (en) begin
			time_left_s1 <= (now >= due) ? '0 : diff[TL_W-1:0];
		end
	end

endmodule

`default_nettype wire

>>> src/sorted_deadline_queue_top.sv
// sorted deadline queue top level: timer entries kept in deadline order
// depends on sdq_pkg and sdq_remaining
//
// usage:
//  - input channel s_axis: one item per command (insert, delete, time to earliest
//    deadline, time left for one id); tdata packs command, entry_id, deadline,
//    current_time from bit 0 up
//  - output channel m_axis: exactly one item per command with time_left,
//    entry_count, head_id and status
//  - deadlines live in a 64-entry memory indexed by id, queue order in a
//    CAPACITY-deep (at most 64) slot memory, both with a registered read port
//  - an insert walks the slot memory backward from the tail, one slot a cycle,
//    shifting entries up until the insert point
//  - a delete scans the slots forward, one a cycle, closing the gap behind the
//    removed id
//  - queries read no slots; after a write the head id and deadline are
//    refreshed from memory into registers
//  - one command is in work at a time; s_axis_tready is high while idle, also
//    while a finished result still waits in the output register
//  - a stalled receiver holds the result in the output register; a further
//    finished result waits until that register is taken
//  - reset empties the queue at once (presence bits and count); the memories
//    need no clearing
`default_nettype none

module sorted_deadline_queue_top #(
	parameter int CAPACITY = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// command[1:0], entry_id[7:2], deadline[71:8], current_time[135:72]
	input  logic [sdq_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// time_left[31:0], entry_count[38:32], head_id[44:39], status[46:45], zero pad
	output logic [sdq_pkg::OUT_W-1:0]  m_axis_tdata
);
	import sdq_pkg::*;

	// only 64 ids exist, so never more slots than that
	localparam int LIMIT = (CAPACITY < ID_SPACE) ? CAPACITY : ID_SPACE;
	localparam int SW    = $clog2(LIMIT);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_INS   = 4'd1;
	localparam logic [3:0] ST_WALK  = 4'd2;
	localparam logic [3:0] ST_PLACE = 4'd3;
	localparam logic [3:0] ST_DELS  = 4'd4;
	localparam logic [3:0] ST_DSCAN = 4'd5;
	localparam logic [3:0] ST_EARLY = 4'd6;
	localparam logic [3:0] ST_QRD   = 4'd7;
	localparam logic [3:0] ST_QRD2  = 4'd8;
	localparam logic [3:0] ST_REF0  = 4'd9;
	localparam logic [3:0] ST_REF1  = 4'd10;
	localparam logic [3:0] ST_REF2  = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;

	// control state
	logic [3:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [ID_SPACE-1:0] present_q;
	logic                out_valid_q;
	logic                issue_q;
	logic                v_s1;
	logic                v_s2;
	logic                found_q;

	// command payload
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [DL_W-1:0]   due_q;
	logic [DL_W-1:0]   now_q;
	logic [STAT_W-1:0] status_q;
	logic              left_use_q;

	// walk and scan bookkeeping
	logic [SW-1:0]   rd_idx_q;
	logic [SW-1:0]   i_s1;
	logic [SW-1:0]   i_s2;
	logic [ID_W-1:0] ord_s2;
	logic [SW-1:0]   pos_q;
	logic            lo_q;
	logic            force_q;

	// cached head
	logic [ID_W-1:0] head_q;
	logic [DL_W-1:0] head_dl_q;

	// output register
	logic [TL_W-1:0]   out_left_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [ID_W-1:0]   out_head_q;
	logic [STAT_W-1:0] out_status_q;

	// memories
	logic [ID_W-1:0] ord_mem [LIMIT];
	logic [DL_W-1:0] dl_mem [ID_SPACE];
	logic [ID_W-1:0] ord_rdata;
	logic [DL_W-1:0] dl_rdata;
	logic            ord_we;
	logic [SW-1:0]   ord_waddr;
	logic [ID_W-1:0] ord_wdata;
	logic [ID_W-1:0] dl_raddr;
	logic            dl_we;

	logic            in_acc;
	logic            hd_gt;
	logic            hd_ge;
	logic            move;
	logic            walk_stop;
	logic [SW-1:0]   last_idx;
	logic [SW-1:0]   lo_idx;
	logic            out_load;
	logic            tl_en;
	logic [DL_W-1:0] tl_due;
	logic [TL_W-1:0] tl_left;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_status_q, out_head_q, out_count_q, out_left_q};

	assign hd_gt    = head_dl_q > due_q;
	assign hd_ge    = head_dl_q >= due_q;
	assign last_idx = SW'(count_q - 1'b1);
	assign lo_idx   = SW'(lo_q);

	// an entry moves up while its deadline is later than the new one,
	// or always when the new entry lands at the head or right after it
	assign move      = force_q || (dl_rdata > due_q);
	assign walk_stop = v_s2 && (!move || (i_s2 == lo_idx));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// slot memory write port
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = pos_q;
		ord_wdata = id_q;
		case (state_q)
			ST_WALK: begin
				ord_we    = v_s2 && move;
				ord_waddr = i_s2 + 1'b1;
				ord_wdata = ord_s2;
			end
			ST_PLACE: begin
				ord_we = 1'b1;
			end
			ST_DSCAN: begin
				// close the gap behind the removed id
				ord_we    = v_s1 && found_q;
				ord_waddr = i_s1 - 1'b1;
				ord_wdata = ord_rdata;
			end
			default: begin
				ord_we = 1'b0;
			end
		endcase
	end

	assign dl_we    = (state_q == ST_PLACE);
	assign dl_raddr = (state_q == ST_QRD) ? id_q : ord_rdata;

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		ord_rdata <= ord_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[id_q] <= due_q;
		end
		dl_rdata <= dl_mem[dl_raddr];
	end

	// time left for the earliest entry or for a queried id
	assign tl_en  = (state_q == ST_EARLY) || (state_q == ST_QRD2);
	assign tl_due = (state_q == ST_QRD2) ? dl_rdata : head_dl_q;

	sdq_remaining u_remaining (
		.clk          (clk),
		.en           (tl_en),
		.due          (tl_due),
		.now          (now_q),
		.time_left_s1 (tl_left)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			present_q   <= '0;
			out_valid_q <= 1'b0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (s_axis_tdata[1:0])
							CMD_INSERT:   state_q <= ST_INS;
							CMD_DELETE:   state_q <= ST_DELS;
							CMD_EARLIEST: state_q <= ST_EARLY;
							default:      state_q <= ST_QRD;
						endcase
					end
				end
				ST_INS: begin
					if (present_q[id_q] || (count_q >= CNT_W'(LIMIT))) begin
						state_q <= ST_DONE;
					end else if ((count_q == '0) || ((count_q == CNT_W'(1)) && !hd_gt)) begin
						state_q <= ST_PLACE;
					end else begin
						issue_q <= 1'b1;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					v_s1 <= issue_q;
					v_s2 <= v_s1;
					if (issue_q && (rd_idx_q == lo_idx)) begin
						issue_q <= 1'b0;
					end
					if (walk_stop) begin
						issue_q <= 1'b0;
						v_s1    <= 1'b0;
						v_s2    <= 1'b0;
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					present_q[id_q] <= 1'b1;
					count_q         <= count_q + 1'b1;
					state_q         <= ST_REF0;
				end
				ST_DELS: begin
					if (!present_q[id_q]) begin
						state_q <= ST_DONE;
					end else begin
						issue_q <= 1'b1;
						found_q <= 1'b0;
						state_q <= ST_DSCAN;
					end
				end
				ST_DSCAN: begin
					v_s1 <= issue_q;
					if (issue_q && (rd_idx_q == last_idx)) begin
						issue_q <= 1'b0;
					end
					if (v_s1 && (ord_rdata == id_q)) begin
						found_q <= 1'b1;
					end
					if (v_s1 && (i_s1 == last_idx)) begin
						present_q[id_q] <= 1'b0;
						count_q         <= count_q - 1'b1;
						v_s1            <= 1'b0;
						issue_q         <= 1'b0;
						state_q         <= ST_REF0;
					end
				end
				ST_EARLY: state_q <= ST_DONE;
				ST_QRD:   state_q <= ST_QRD2;
				ST_QRD2:  state_q <= ST_DONE;
				ST_REF0: begin
					state_q <= (count_q == '0) ? ST_DONE : ST_REF1;
				end
				ST_REF1:  state_q <= ST_REF2;
				ST_REF2:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd_q      <= s_axis_tdata[1:0];
					id_q       <= s_axis_tdata[7:2];
					due_q      <= s_axis_tdata[71:8];
					now_q      <= s_axis_tdata[135:72];
					status_q   <= STAT_OK;
					left_use_q <= 1'b0;
				end
			end
			ST_INS: begin
				if (present_q[id_q]) begin
					status_q <= STAT_DUP;
				end else if (count_q >= CNT_W'(LIMIT)) begin
					status_q <= STAT_FULL;
				end
				// empty queue: slot 0; one entry not above the new one: slot 1
				pos_q    <= (count_q == '0) ? '0 : SW'(1);
				lo_q     <= !hd_gt;
				force_q  <= hd_ge;
				rd_idx_q <= last_idx;
			end
			ST_WALK: begin
				i_s1   <= rd_idx_q;
				i_s2   <= i_s1;
				ord_s2 <= ord_rdata;
				if (issue_q && (rd_idx_q != lo_idx)) begin
					rd_idx_q <= rd_idx_q - 1'b1;
				end
				if (walk_stop) begin
					pos_q <= move ? lo_idx : (i_s2 + 1'b1);
				end
			end
			ST_PLACE: begin
				rd_idx_q <= '0;
			end
			ST_DELS: begin
				rd_idx_q <= '0;
				if (!present_q[id_q]) begin
					status_q <= STAT_MISSING;
				end
			end
			ST_DSCAN: begin
				i_s1 <= rd_idx_q;
				if (issue_q && (rd_idx_q != last_idx)) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (v_s1 && (i_s1 == last_idx)) begin
					rd_idx_q <= '0;
				end
			end
			ST_EARLY: begin
				left_use_q <= (count_q != '0);
			end
			ST_QRD2: begin
				left_use_q <= present_q[id_q];
				status_q   <= present_q[id_q] ? STAT_OK : STAT_MISSING;
			end
			ST_REF1: begin
				head_q <= ord_rdata;
			end
			ST_REF2: begin
				head_dl_q <= dl_rdata;
			end
			ST_DONE: begin
				if (out_load) begin
					out_left_q   <= left_use_q ? tl_left : '0;
					out_count_q  <= count_q;
					out_head_q   <= (count_q != '0) ? head_q : '0;
					out_status_q <= status_q;
				end
			end
			default: begin
				rd_idx_q <= rd_idx_q;
			end
		endcase
	end

	// the count always tracks the presence bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(present_q)))
		else $error("entry count differs from presence bits");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIMIT))
		else $error("entry count above capacity");

	// slot writes stay inside the occupied range plus the new tail
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ord_we |-> (CNT_W'(ord_waddr) <= count_q))
		else $error("slot write beyond queue tail");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && cmd_q == CMD_INSERT && status_q == STAT_FULL)
			|-> (count_q == CNT_W'(LIMIT)))
		else $error("full reported below capacity");

	// a pending result is never overwritten
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
		else $error("result finished while output stalled");

endmodule

`default_nettype wire

>>> verif/tb_sorted_deadline_queue_top.sv
// self-checking bench for sorted_deadline_queue_top: directed and random timer commands
// driven over the input stream and checked against an in-bench model of the deadline queue
// depends on sdq_pkg and the sorted_deadline_queue_top rtl
`default_nettype none

module tb_sorted_deadline_queue_top;

	import sdq_pkg::*;

	localparam int SLOTS       = 64;
	localparam int QUEUE_LIMIT = (SLOTS < ID_SPACE) ? SLOTS : ID_SPACE;
	localparam int RANDOM_CMDS = 1725;
	localparam int SETTLE_GAP  = 120;   // cycles after the last result, longer than a full walk

	// one command as the sender sees it; settle marks a hold point, not an item
	typedef struct {
		bit                settle;
		logic [CMD_W-1:0]  cmd;
		logic [ID_W-1:0]   id;
		logic [DL_W-1:0]   due;
		logic [DL_W-1:0]   now;
	} timer_cmd_t;

	// result fields in output bit order, lowest field last
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   head;
		logic [CNT_W-1:0]  count;
		logic [TL_W-1:0]   time_left;
	} reply_t;

	logic             clk     = 1'b0;
	logic             arst_n  = 1'b0;
	logic             s_valid = 1'b0;
	logic [IN_W-1:0]  s_data  = '0;
	logic             m_ready = 1'b0;
	logic             s_ready;
	logic             m_valid;
	logic [OUT_W-1:0] m_data;

	sorted_deadline_queue_top #(
		.CAPACITY(SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (s_data),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_data)
	);

	// stimulus plan and results still owed by the block
	timer_cmd_t command_backlog[$];
	reply_t     awaited_results[$];
	int         planned_total = 0;
	int         sent_count    = 0;
	int         checked_count = 0;
	int         fault_count   = 0;
	logic       calm          = 1'b0;   // no idling on either side near the end
	int         calm_from     = 0;

	// model state: deadline per id, ids in queue order, presence, occupancy
	logic [DL_W-1:0] due_of[ID_SPACE];
	logic [ID_W-1:0] lineup[ID_SPACE];
	bit              queued[ID_SPACE];
	int              queued_count = 0;

	// coverage tallies for the closing summary
	int cmd_tally[4];
	int status_tally[4];
	int peak_count = 0;

	// plan-time view of which ids are queued, used to aim commands at live entries
	bit              plan_held[ID_SPACE];
	int              plan_count = 0;
	logic [DL_W-1:0] plan_clock = 64'd5000;
	logic [DL_W-1:0] recent_due[$];

	initial forever #5 clk = ~clk;

	// remaining time, zero once the deadline is reached, cut to 32 bits
	function automatic logic [TL_W-1:0] time_to(logic [DL_W-1:0] due, logic [DL_W-1:0] now);
		logic [DL_W-1:0] diff;
		if (now >= due)
			return '0;
		diff = due - now;
		return diff[TL_W-1:0];
	endfunction

	// applies one accepted command to the model and returns the result it owes
	function automatic reply_t apply_command(timer_cmd_t c);
		reply_t          r;
		int              pos;
		int              i;
		logic [DL_W-1:0] head_due;
		r = '0;
		case (c.cmd)
			CMD_INSERT: begin
				if (queued[c.id]) begin
					r.status = STAT_DUP;
				end else if (queued_count >= QUEUE_LIMIT) begin
					r.status = STAT_FULL;
				end else begin
					pos = 0;
					if (queued_count > 0) begin
						head_due = due_of[lineup[0]];
						// a tie with the head lands right behind it
						if (head_due == c.due) begin
							pos = 1;
						end else if (head_due < c.due) begin
							// otherwise after the last entry not later than the new one
							i = queued_count - 1;
							while (i > 0 && due_of[lineup[i]] > c.due)
								i--;
							pos = i + 1;
						end
					end
					for (i = queued_count; i > pos; i--)
						lineup[i] = lineup[i-1];
					lineup[pos] = c.id;
					due_of[c.id] = c.due;
					queued[c.id] = 1'b1;
					queued_count++;
				end
			end
			CMD_DELETE: begin
				if (!queued[c.id]) begin
					r.status = STAT_MISSING;
				end else begin
					pos = 0;
					while (lineup[pos] != c.id)
						pos++;
					for (i = pos; i + 1 < queued_count; i++)
						lineup[i] = lineup[i+1];
					queued[c.id] = 1'b0;
					queued_count--;
				end
			end
			CMD_EARLIEST: begin
				if (queued_count > 0)
					r.time_left = time_to(due_of[lineup[0]], c.now);
			end
			CMD_QUERY: begin
				if (queued[c.id])
					r.time_left = time_to(due_of[c.id], c.now);
				else
					r.status = STAT_MISSING;
			end
		endcase
		r.count = queued_count[CNT_W-1:0];
		r.head  = (queued_count > 0) ? lineup[0] : '0;
		cmd_tally[c.cmd]++;
		status_tally[r.status]++;
		if (queued_count > peak_count)
			peak_count = queued_count;
		return r;
	endfunction

	// idle rate for the next stretch, in percent; zero gives stretches without idling
	function automatic int pick_idle_rate();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 20;
			default: return 50;
		endcase
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fault_count++;
		end
	endtask

	// queues one command and follows its effect on the plan-time id view
	function automatic void plan(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
			logic [DL_W-1:0] due, logic [DL_W-1:0] now);
		timer_cmd_t c;
		c.settle = 1'b0;
		c.cmd    = cmd;
		c.id     = id;
		c.due    = due;
		c.now    = now;
		command_backlog.push_back(c);
		planned_total++;
		if (cmd == CMD_INSERT && !plan_held[id] && plan_count < QUEUE_LIMIT) begin
			plan_held[id] = 1'b1;
			plan_count++;
			recent_due.push_back(due);
			if (recent_due.size() > 16)
				void'(recent_due.pop_front());
		end else if (cmd == CMD_DELETE && plan_held[id]) begin
			plan_held[id] = 1'b0;
			plan_count--;
		end
	endfunction

	// hold point: the sender waits here until every owed result is back
	function automatic void plan_settle();
		timer_cmd_t c;
		c = '{settle: 1'b1, cmd: CMD_EARLIEST, id: '0, due: '0, now: '0};
		command_backlog.push_back(c);
	endfunction

	// id that is queued (or not) when one exists, else any id
	function automatic logic [ID_W-1:0] pick_id(bit held);
		int start;
		int k;
		logic [ID_W-1:0] cand;
		start = $urandom_range(0, ID_SPACE - 1);
		for (k = 0; k < ID_SPACE; k++) begin
			cand = ID_W'(start + k);
			if (plan_held[cand] == held)
				return cand;
		end
		return ID_W'(start);
	endfunction

	function automatic logic [DL_W-1:0] pick_due();
		case ($urandom_range(0, 19))
			0, 1: return {$urandom, $urandom};
			2: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return plan_clock;
					default: return 64'h0000_0000_FFFF_FFFF;
				endcase
			end
			3, 4, 5, 6: begin
				// ties with earlier deadlines, the head's among them
				if (recent_due.size() > 0)
					return recent_due[$urandom_range(0, recent_due.size() - 1)];
				return plan_clock + $urandom_range(0, 4000);
			end
			7, 8: return plan_clock + {8'd0, 24'($urandom), $urandom};  // beyond 32 bits
			default: return plan_clock + $urandom_range(0, 4000);
		endcase
	endfunction

	function automatic logic [DL_W-1:0] pick_now();
		logic [DL_W-1:0] d;
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: return $urandom_range(0, 1) ? '0 : '1;
			2, 3: begin
				// right at a deadline, one before, one after
				if (recent_due.size() == 0)
					return plan_clock;
				d = recent_due[$urandom_range(0, recent_due.size() - 1)];
				return d + $urandom_range(0, 2) - 1;
			end
			default: return plan_clock + $urandom_range(0, 3000);
		endcase
	endfunction

	// command mix per phase: filling, emptying or mixed
	function automatic logic [CMD_W-1:0] pick_cmd(int phase);
		int roll;
		roll = $urandom_range(0, 99);
		case (phase)
			0: return roll < 70 ? CMD_INSERT : roll < 80 ? CMD_DELETE :
				roll < 90 ? CMD_EARLIEST : CMD_QUERY;
			1: return roll < 15 ? CMD_INSERT : roll < 75 ? CMD_DELETE :
				roll < 87 ? CMD_EARLIEST : CMD_QUERY;
			default: return roll < 35 ? CMD_INSERT : roll < 60 ? CMD_DELETE :
				roll < 80 ? CMD_EARLIEST : CMD_QUERY;
		endcase
	endfunction

	// stimulus plan, reset and end of run
	initial begin
		int               phase;
		int               run_len;
		int               made;
		int               k;
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  id;

		// directed: empty queue cases
		plan(CMD_EARLIEST, 6'd0, '0, 64'd123);
		plan(CMD_QUERY, 6'd0, '0, 64'd0);
		plan(CMD_DELETE, 6'd63, '0, '1);
		// inserts: first entry, duplicate, ties with the head, new head, tail, extremes
		plan(CMD_INSERT, 6'd5, 64'd1000, '0);
		plan(CMD_INSERT, 6'd5, 64'd7, '0);
		plan(CMD_INSERT, 6'd9, 64'd1000, '0);
		plan(CMD_INSERT, 6'd12, 64'd1000, '0);
		plan(CMD_INSERT, 6'd3, 64'd500, '0);
		plan(CMD_INSERT, 6'd0, '1, '0);
		plan(CMD_INSERT, 6'd63, '0, '1);
		plan(CMD_INSERT, 6'd20, 64'd2000, '0);
		plan(CMD_INSERT, 6'd33, 64'h1_0000_0000, '0);
		// queries: expired head, full-width truncation, exact 2^32, boundaries
		plan(CMD_EARLIEST, 6'd0, '0, 64'd0);
		plan(CMD_QUERY, 6'd0, '0, 64'd0);
		plan(CMD_QUERY, 6'd0, '0, '1);
		plan(CMD_QUERY, 6'd33, '0, 64'd0);
		plan(CMD_QUERY, 6'd20, '0, 64'd1999);
		plan(CMD_QUERY, 6'd20, '0, 64'd2000);
		plan(CMD_QUERY, 6'd20, '0, 64'd2001);
		// deletes: head, tail, middle, then a query for an absent id
		plan(CMD_DELETE, 6'd63, '0, '0);
		plan(CMD_EARLIEST, 6'd0, '0, 64'd400);
		plan(CMD_DELETE, 6'd0, '0, '0);
		plan(CMD_DELETE, 6'd9, '0, '0);
		plan(CMD_QUERY, 6'd9, '0, 64'd10);
		plan_settle();

		// random phases; the first one fills the queue to the brim
		made  = 0;
		phase = 0;
		while (made < RANDOM_CMDS) begin
			run_len = (made == 0) ? 160 : $urandom_range(40, 120);
			for (k = 0; k < run_len && made < RANDOM_CMDS; k++) begin
				cmd = pick_cmd(phase);
				case (cmd)
					CMD_INSERT: id = pick_id($urandom_range(0, 99) < 12);
					CMD_DELETE: id = pick_id($urandom_range(0, 99) < 88);
					default:    id = pick_id($urandom_range(0, 99) < 80);
				endcase
				plan(cmd, id, pick_due(), pick_now());
				plan_clock += $urandom_range(0, 20);
				if ($urandom_range(0, 199) == 0)
					plan_clock = {$urandom, $urandom};
				made++;
				if (made % 500 == 0)
					plan_settle();
			end
			phase = $urandom_range(0, 2);
		end
		calm_from = planned_total - planned_total / 8;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_count < planned_total || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);

		$display("ran %0d inserts, %0d deletes, %0d earliest and %0d per-id queries, peak %0d held",
			cmd_tally[CMD_INSERT], cmd_tally[CMD_DELETE], cmd_tally[CMD_EARLIEST],
			cmd_tally[CMD_QUERY], peak_count);
		$display("statuses ok %0d, full %0d, missing %0d, duplicate %0d; %0d results checked",
			status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_MISSING],
			status_tally[STAT_DUP], checked_count);
		if (fault_count == 0)
			$display("sorted_deadline_queue_top test passed");
		else
			$display("sorted_deadline_queue_top test failed");
		$finish;
	end

	// watchdog, far above the slowest correct run
	initial begin
		#10_000_000;
		$display("sorted_deadline_queue_top test failed");
		$finish;
	end

	// sender: predicts on each accepted item, then offers the next one or idles
	always @(posedge clk or negedge arst_n) begin : sender
		timer_cmd_t live_cmd;
		int         gap_left;
		int         gap_pct;
		logic       offer;
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data  <= '0;
			gap_left = 0;
			gap_pct  = 0;
		end else begin
			if (s_valid && s_ready) begin
				awaited_results.push_back(apply_command(live_cmd));
				sent_count++;
				if (sent_count % 64 == 0)
					gap_pct = pick_idle_rate();
			end
			calm <= (sent_count >= calm_from);
			if (!s_valid || s_ready) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (command_backlog.size() > 0) begin
					if (command_backlog[0].settle) begin
						// hold until the block has returned everything
						if (awaited_results.size() == 0)
							void'(command_backlog.pop_front());
					end else begin
						live_cmd = command_backlog.pop_front();
						offer = 1'b1;
						if (!calm && $urandom_range(0, 99) < gap_pct)
							gap_left = $urandom_range(1, 14);
					end
				end
				s_valid <= offer;
				if (offer)
					s_data <= {live_cmd.now, live_cmd.due, live_cmd.id, live_cmd.cmd};
			end
		end
	end

	// receiver: checks each accepted result against the oldest owed one, stalls in bursts
	always @(posedge clk or negedge arst_n) begin : receiver
		reply_t got;
		reply_t want;
		int     stall_left;
		int     stall_pct;
		if (!arst_n) begin
			m_ready <= 1'b0;
			stall_left = 0;
			stall_pct  = 0;
		end else begin
			if (m_valid && m_ready) begin
				got = m_data[$bits(reply_t)-1:0];
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0h", $time, got);
					fault_count++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("time_left", 64'(want.time_left), 64'(got.time_left));
					compare_field("entry_count", 64'(want.count), 64'(got.count));
					compare_field("head_id", 64'(want.head), 64'(got.head));
					compare_field("status", 64'(want.status), 64'(got.status));
				end
				checked_count++;
				if (checked_count % 64 == 0)
					stall_pct = pick_idle_rate();
			end
			if (stall_left > 0) begin
				stall_left--;
				m_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 13);
				m_ready <= 1'b0;
			end else begin
				m_ready <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
